// File: hw/rtl/process_dispatcher_with_wait_queues_unit_macros.svh
// assertion macros shared by the dispatcher rtl
`ifndef PROCESS_DISPATCHER_WITH_WAIT_QUEUES_UNIT_MACROS_SVH
`define PROCESS_DISPATCHER_WITH_WAIT_QUEUES_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PDWQ_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`define PDWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define PDWQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define PDWQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/pdwq_pkg.sv
// shared codes and types of the process dispatcher
package pdwq_pkg;

   localparam logic [2:0] ST_UNUSED = 3'd0;
   localparam logic [2:0] ST_READY  = 3'd1;
   localparam logic [2:0] ST_RUN    = 3'd2;
   localparam logic [2:0] ST_BLOCK  = 3'd3;
   localparam logic [2:0] ST_EXIT   = 3'd4;
   localparam logic [2:0] ST_IDLE   = 3'd5;

   localparam logic [2:0] MODE_CREATE    = 3'd0;
   localparam logic [2:0] MODE_EXIT      = 3'd1;
   localparam logic [2:0] MODE_REQUEST   = 3'd2;
   localparam logic [2:0] MODE_INTERRUPT = 3'd3;
   localparam logic [2:0] MODE_TIMER     = 3'd4;
   localparam logic [2:0] MODE_REPORT    = 3'd5;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_BAD = 2'd2;

   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 112;

   typedef enum logic [1:0] {
      QOP_PUSH   = 2'd0,
      QOP_POP    = 2'd1,
      QOP_REMOVE = 2'd2
   } qop_type;

   typedef struct packed {
      logic    start;
      qop_type op;
   } qcmd_type;

   typedef struct packed {
      logic done;
      logic ready_nz;
   } qstat_type;

   typedef struct packed {
      logic       charge;
      logic       clear;
      logic [2:0] kind;
   } acc_ctl_type;

endpackage

// File: hw/rtl/pdwq_queue_bank.sv
// ready queue and wait queues in one memory, with push, pop and remove-by-rotation
`include "process_dispatcher_with_wait_queues_unit_macros.svh"

module pdwq_queue_bank #(
   parameter int SLOTS  = 32,
   parameter int QUEUES = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pdwq_pkg::qcmd_type         cmd,
   input  logic [$clog2(QUEUES)-1:0]  q_sel,
   input  logic [$clog2(SLOTS)-1:0]   value,
   output pdwq_pkg::qstat_type        stat,
   output logic [$clog2(SLOTS)-1:0]   pop_value
);

   localparam int IW = $clog2(SLOTS);
   localparam int QW = $clog2(QUEUES);
   localparam int MEM_DEPTH = 1 << (QW + IW);
   localparam logic [IW:0] SLOTS_W = (IW + 1)'(SLOTS);

   typedef enum logic [3:0] {
      Q_IDLE     = 4'b0001,
      Q_POP      = 4'b0010,
      Q_RM_READ  = 4'b0100,
      Q_RM_CHECK = 4'b1000
   } qstate_type;

   qstate_type          state_ff, state_in;
   logic [IW-1:0]       head_ff  [QUEUES];
   logic [IW-1:0]       count_ff [QUEUES];
   logic [QW-1:0]       q_ff, q_in;
   logic [IW-1:0]       val_ff, val_in;
   logic [IW-1:0]       num_ff, num_in;
   logic [IW-1:0]       iter_ff, iter_in;
   logic                done_ff, done_in;
   logic [IW-1:0]       pop_ff, pop_in;
   logic [IW-1:0]       rd_data_ff;
   logic [IW-1:0]       mem [MEM_DEPTH];

   logic [QW-1:0]       qa;
   logic [IW-1:0]       head_cur, count_cur, head_nx, tail;
   logic [IW:0]         tail_sum;
   logic [IW:0]         iter_nx;
   logic                we, ptr_we;
   logic [IW-1:0]       head_w, count_w, wr_data;

   always_comb begin
      qa        = (state_ff == Q_IDLE) ? q_sel : q_ff;
      head_cur  = head_ff[qa];
      count_cur = count_ff[qa];
      head_nx   = (32'(head_cur) == SLOTS - 1) ? '0 : head_cur + 1'b1;
      tail_sum  = {1'b0, head_cur} + {1'b0, count_cur};
      tail      = (tail_sum >= SLOTS_W) ? IW'(tail_sum - SLOTS_W) : tail_sum[IW-1:0];
      wr_data   = (state_ff == Q_IDLE) ? value : rd_data_ff;
      iter_nx   = {1'b0, iter_ff} + 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      q_in     = q_ff;
      val_in   = val_ff;
      num_in   = num_ff;
      iter_in  = iter_ff;
      done_in  = 1'b0;
      pop_in   = pop_ff;
      we       = 1'b0;
      ptr_we   = 1'b0;
      head_w   = head_cur;
      count_w  = count_cur;
      case (state_ff)
         Q_IDLE: begin
            if (cmd.start) begin
               q_in    = q_sel;
               val_in  = value;
               num_in  = count_cur;
               iter_in = '0;
               case (cmd.op)
                  pdwq_pkg::QOP_PUSH: begin
                     we      = 1'b1;
                     ptr_we  = 1'b1;
                     count_w = count_cur + 1'b1;
                     done_in = 1'b1;
                  end
                  pdwq_pkg::QOP_POP: begin
                     state_in = Q_POP;
                  end
                  pdwq_pkg::QOP_REMOVE: begin
                     if (count_cur == '0) begin
                        done_in = 1'b1;
                     end else begin
                        state_in = Q_RM_CHECK;
                     end
                  end
                  default: begin
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         Q_POP: begin
            pop_in   = rd_data_ff;
            ptr_we   = 1'b1;
            head_w   = head_nx;
            count_w  = count_cur - 1'b1;
            done_in  = 1'b1;
            state_in = Q_IDLE;
         end
         Q_RM_READ: begin
            state_in = Q_RM_CHECK;
         end
         Q_RM_CHECK: begin
            ptr_we = 1'b1;
            head_w = head_nx;
            if (rd_data_ff == val_ff) begin
               count_w  = count_cur - 1'b1;
               done_in  = 1'b1;
               state_in = Q_IDLE;
            end else begin
               // front entry goes to the back
               we      = 1'b1;
               iter_in = iter_nx[IW-1:0];
               if (iter_nx == {1'b0, num_ff}) begin
                  done_in  = 1'b1;
                  state_in = Q_IDLE;
               end else begin
                  state_in = Q_RM_READ;
               end
            end
         end
         default: begin
            state_in = Q_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[{qa, head_cur}];
      if (we) begin
         mem[{qa, tail}] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         done_ff  <= 1'b0;
         for (int i = 0; i < QUEUES; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         if (ptr_we) begin
            head_ff[qa]  <= head_w;
            count_ff[qa] <= count_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      val_ff  <= val_in;
      num_ff  <= num_in;
      iter_ff <= iter_in;
      pop_ff  <= pop_in;
   end

   assign stat.done     = done_ff;
   assign stat.ready_nz = (count_ff[0] != '0);
   assign pop_value     = pop_ff;

   `PDWQ_ASSERT_IMPL(a_start_when_idle, cmd.start, state_ff == Q_IDLE, "queue command while busy")
   `PDWQ_ASSERT_NEXT(a_done_single, done_ff, !done_ff, "queue done held two cycles")
   `PDWQ_ASSERT_IMPL(a_check_nonempty, state_ff == Q_RM_CHECK, count_ff[q_ff] != '0, "remove on empty queue")

endmodule

// File: hw/rtl/pdwq_acc_bank.sv
// per-slot run, ready and block totals with one shared saturating adder
module pdwq_acc_bank #(
   parameter int SLOTS = 32,
   parameter int TBITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pdwq_pkg::acc_ctl_type     ctl,
   input  logic [$clog2(SLOTS)-1:0]  rd_slot,
   input  logic [$clog2(SLOTS)-1:0]  clear_slot,
   input  logic [31:0]               delta,
   output logic [TBITS-1:0]          run_tot,
   output logic [TBITS-1:0]          ready_tot,
   output logic [TBITS-1:0]          block_tot
);

   localparam int IW = $clog2(SLOTS);
   localparam int SUMW = ((TBITS > 32) ? TBITS : 32) + 1;
   localparam logic [TBITS-1:0] TMAX = {TBITS{1'b1}};

   logic [TBITS-1:0] run_mem [SLOTS];
   logic [TBITS-1:0] rdy_mem [SLOTS];
   logic [TBITS-1:0] blk_mem [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   logic             valid_rd_ff;
   logic [IW-1:0]    slot_ff;
   logic [TBITS-1:0] run_raw_ff, rdy_raw_ff, blk_raw_ff;

   logic [TBITS-1:0] sel, sat;
   logic [SUMW-1:0]  sum;
   logic             wr_en;
   logic [TBITS-1:0] new_run, new_rdy, new_blk;

   assign run_tot   = valid_rd_ff ? run_raw_ff : '0;
   assign ready_tot = valid_rd_ff ? rdy_raw_ff : '0;
   assign block_tot = valid_rd_ff ? blk_raw_ff : '0;

   always_comb begin
      new_run = run_tot;
      new_rdy = ready_tot;
      new_blk = block_tot;
      wr_en   = 1'b0;
      case (ctl.kind)
         pdwq_pkg::ST_RUN:   sel = run_tot;
         pdwq_pkg::ST_READY: sel = ready_tot;
         pdwq_pkg::ST_BLOCK: sel = block_tot;
         default:            sel = '0;
      endcase
      sum = SUMW'(sel) + SUMW'(delta);
      sat = (sum > SUMW'(TMAX)) ? TMAX : sum[TBITS-1:0];
      case (ctl.kind)
         pdwq_pkg::ST_RUN: begin
            new_run = sat;
            wr_en   = ctl.charge;
         end
         pdwq_pkg::ST_READY: begin
            new_rdy = sat;
            wr_en   = ctl.charge;
         end
         pdwq_pkg::ST_BLOCK: begin
            new_blk = sat;
            wr_en   = ctl.charge;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      run_raw_ff <= run_mem[rd_slot];
      rdy_raw_ff <= rdy_mem[rd_slot];
      blk_raw_ff <= blk_mem[rd_slot];
      slot_ff    <= rd_slot;
      if (wr_en) begin
         run_mem[slot_ff] <= new_run;
         rdy_mem[slot_ff] <= new_rdy;
         blk_mem[slot_ff] <= new_blk;
      end
   end

   // a slot without its valid bit reads as zero totals
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         valid_rd_ff <= 1'b0;
      end else begin
         valid_rd_ff <= valid_ff[rd_slot];
         if (ctl.clear) begin
            valid_ff[clear_slot] <= 1'b0;
         end else if (wr_en) begin
            valid_ff[slot_ff] <= 1'b1;
         end
      end
   end

endmodule

// File: hw/rtl/process_dispatcher_with_wait_queues_unit.sv
// time charge runs over every slot (LIM = min(PROC_SLOTS,32)) in S_CHARGE and S_CHG_LAST, then decode
//   a plain event then goes to S_RESULT, which registers its result
// a queue remove moves each entry that does not match to the back, through Q_RM_CHECK and Q_RM_READ
// a report walks slots through S_REP_RD and S_REP_CHK and sends each reported slot through S_OUT
// one event at a time: the next request is taken after the last result is taken
// reset: synchronous, clears slot states, queue pointers and total valid bits at once
`include "process_dispatcher_with_wait_queues_unit_macros.svh"

module process_dispatcher_with_wait_queues_unit #(
   parameter int PROC_SLOTS  = 32,
   parameter int WAIT_QUEUES = 5,
   parameter int TIME_BITS   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // event_time[31:0], resource[34:32], process_id[39:35]
   input  logic [pdwq_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // mode[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // running_pid[4:0], slot_pid[9:5], run_total[41:10], ready_total[73:42],
   // block_total[105:74], slot_status[108:106], status[110:109], zero[111]
   output logic [pdwq_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // is_report[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   localparam int LIM = (PROC_SLOTS < 32) ? PROC_SLOTS : 32;
   localparam int IW  = $clog2(LIM);
   localparam int NQ  = WAIT_QUEUES + 1;
   localparam int QW  = $clog2(NQ);
   localparam logic [IW-1:0] LAST_SLOT = IW'(LIM - 1);

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_CHARGE   = 13'b0000000000010,
      S_CHG_LAST = 13'b0000000000100,
      S_DECODE   = 13'b0000000001000,
      S_QWAIT    = 13'b0000000010000,
      S_REQ_RM   = 13'b0000000100000,
      S_INT_PUSH = 13'b0000001000000,
      S_DISPATCH = 13'b0000010000000,
      S_DISP_SET = 13'b0000100000000,
      S_RESULT   = 13'b0001000000000,
      S_REP_RD   = 13'b0010000000000,
      S_REP_CHK  = 13'b0100000000000,
      S_OUT      = 13'b1000000000000
   } state_type;

   state_type     state_ff, state_in, nxt_ff, nxt_in;
   logic [2:0]    mode_ff, mode_in;
   logic [2:0]    res_ff, res_in;
   logic [4:0]    pid_ff, pid_in;
   logic [31:0]   delta_ff, delta_in;
   logic [31:0]   prev_ff, prev_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] hi_ff, hi_in;
   logic [2:0]    kind_ff, kind_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] run_ff, run_in;
   logic [1:0]    status_ff, status_in;
   logic [2:0]    st_ff [LIM];
   logic [2:0]    wt_ff [LIM];

   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [pdwq_pkg::RSP_TDATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic          rsp_tuser_ff, rsp_tuser_in;
   logic          rsp_tlast_ff, rsp_tlast_in;

   logic [IW-1:0] st_addr, st_waddr, pidx;
   logic [2:0]    st_rd, wt_rd, st_wdata, wt_wdata, slot_kind;
   logic          st_we, pok, rok, wok;
   logic [31:0]   evt_time;

   pdwq_pkg::qcmd_type    q_cmd;
   pdwq_pkg::qstat_type   q_stat;
   logic [QW-1:0]         q_sel;
   logic [IW-1:0]         q_value, pop_value;
   pdwq_pkg::acc_ctl_type acc_ctl;
   logic [TIME_BITS-1:0]  run_tot, ready_tot, block_tot;

   pdwq_queue_bank #(.SLOTS(LIM), .QUEUES(NQ)) u_queues (
      .clock     (clock),
      .reset     (reset),
      .cmd       (q_cmd),
      .q_sel     (q_sel),
      .value     (q_value),
      .stat      (q_stat),
      .pop_value (pop_value)
   );

   pdwq_acc_bank #(.SLOTS(LIM), .TBITS(TIME_BITS)) u_totals (
      .clock      (clock),
      .reset      (reset),
      .ctl        (acc_ctl),
      .rd_slot    (idx_ff),
      .clear_slot (pidx),
      .delta      (delta_ff),
      .run_tot    (run_tot),
      .ready_tot  (ready_tot),
      .block_tot  (block_tot)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign evt_time   = req_tdata[31:0];

   always_comb begin
      pidx      = pid_ff[IW-1:0];
      st_addr   = (state_ff == S_DECODE) ? pidx : idx_ff;
      st_rd     = st_ff[st_addr];
      wt_rd     = wt_ff[st_addr];
      pok       = (pid_ff != '0) && (32'(pid_ff) < PROC_SLOTS);
      rok       = (res_ff != '0) && (32'(res_ff) <= WAIT_QUEUES);
      wok       = (wt_rd != '0) && (32'(wt_rd) <= WAIT_QUEUES);
      // slot 0 is the idle process
      slot_kind = (idx_ff == '0) ? ((run_ff == '0) ? pdwq_pkg::ST_RUN : pdwq_pkg::ST_IDLE)
                                 : st_rd;
   end

   always_comb begin
      state_in      = state_ff;
      nxt_in        = nxt_ff;
      mode_in       = mode_ff;
      res_in        = res_ff;
      pid_in        = pid_ff;
      delta_in      = delta_ff;
      prev_in       = prev_ff;
      idx_in        = idx_ff;
      hi_in         = hi_ff;
      kind_in       = kind_ff;
      pend_in       = pend_ff;
      run_in        = run_ff;
      status_in     = status_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      st_we         = 1'b0;
      st_waddr      = pidx;
      st_wdata      = pdwq_pkg::ST_UNUSED;
      wt_wdata      = '0;
      q_cmd.start   = 1'b0;
      q_cmd.op      = pdwq_pkg::QOP_PUSH;
      q_sel         = '0;
      q_value       = pidx;
      acc_ctl.charge = 1'b0;
      acc_ctl.clear  = 1'b0;
      acc_ctl.kind   = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in   = req_tuser;
               res_in    = req_tdata[34:32];
               pid_in    = req_tdata[39:35];
               delta_in  = (evt_time >= prev_ff) ? evt_time - prev_ff : '0;
               prev_in   = evt_time;
               idx_in    = '0;
               hi_in     = '0;
               pend_in   = 1'b0;
               status_in = pdwq_pkg::STATUS_OK;
               state_in  = S_CHARGE;
            end
         end
         S_CHARGE: begin
            // read slot idx while the previous slot is written back
            acc_ctl.charge = pend_ff;
            kind_in = slot_kind;
            pend_in = 1'b1;
            if (idx_ff != '0 && st_rd != pdwq_pkg::ST_UNUSED) begin
               hi_in = idx_ff;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = S_CHG_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_CHG_LAST: begin
            acc_ctl.charge = pend_ff;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = S_RESULT;
            case (mode_ff)
               pdwq_pkg::MODE_CREATE: begin
                  if (!pok || !(st_rd == pdwq_pkg::ST_UNUSED || st_rd == pdwq_pkg::ST_EXIT)) begin
                     status_in = pdwq_pkg::STATUS_BAD;
                  end else begin
                     acc_ctl.clear = 1'b1;
                     st_we = 1'b1;
                     if (run_ff != '0) begin
                        st_wdata    = pdwq_pkg::ST_READY;
                        q_cmd.start = 1'b1;
                        nxt_in      = S_RESULT;
                        state_in    = S_QWAIT;
                     end else begin
                        st_wdata = pdwq_pkg::ST_RUN;
                        run_in   = pidx;
                     end
                  end
               end
               pdwq_pkg::MODE_EXIT: begin
                  if (!pok) begin
                     status_in = pdwq_pkg::STATUS_BAD;
                  end else if (st_rd == pdwq_pkg::ST_RUN) begin
                     st_we    = 1'b1;
                     st_wdata = pdwq_pkg::ST_EXIT;
                     run_in   = '0;
                     state_in = S_DISPATCH;
                  end else if (st_rd == pdwq_pkg::ST_READY) begin
                     st_we       = 1'b1;
                     st_wdata    = pdwq_pkg::ST_EXIT;
                     q_cmd.start = 1'b1;
                     q_cmd.op    = pdwq_pkg::QOP_REMOVE;
                     nxt_in      = S_RESULT;
                     state_in    = S_QWAIT;
                  end else if (st_rd == pdwq_pkg::ST_BLOCK) begin
                     st_we    = 1'b1;
                     st_wdata = pdwq_pkg::ST_EXIT;
                     if (wok) begin
                        q_cmd.start = 1'b1;
                        q_cmd.op    = pdwq_pkg::QOP_REMOVE;
                        q_sel       = QW'(wt_rd);
                        nxt_in      = S_RESULT;
                        state_in    = S_QWAIT;
                     end
                  end else begin
                     status_in = pdwq_pkg::STATUS_BAD;
                  end
               end
               pdwq_pkg::MODE_REQUEST: begin
                  if (!pok || !rok ||
                      !(st_rd == pdwq_pkg::ST_RUN || st_rd == pdwq_pkg::ST_READY)) begin
                     status_in = pdwq_pkg::STATUS_BAD;
                  end else begin
                     st_we       = 1'b1;
                     st_wdata    = pdwq_pkg::ST_BLOCK;
                     wt_wdata    = res_ff;
                     q_cmd.start = 1'b1;
                     q_sel       = QW'(res_ff);
                     state_in    = S_QWAIT;
                     if (st_rd == pdwq_pkg::ST_READY) begin
                        nxt_in = S_REQ_RM;
                     end else begin
                        run_in = '0;
                        nxt_in = S_DISPATCH;
                     end
                  end
               end
               pdwq_pkg::MODE_INTERRUPT: begin
                  if (!pok || !rok || st_rd != pdwq_pkg::ST_BLOCK || wt_rd != res_ff) begin
                     status_in = pdwq_pkg::STATUS_BAD;
                  end else begin
                     st_we       = 1'b1;
                     q_cmd.start = 1'b1;
                     q_cmd.op    = pdwq_pkg::QOP_REMOVE;
                     q_sel       = QW'(res_ff);
                     state_in    = S_QWAIT;
                     if (run_ff == '0) begin
                        st_wdata = pdwq_pkg::ST_RUN;
                        run_in   = pidx;
                        nxt_in   = S_RESULT;
                     end else begin
                        st_wdata = pdwq_pkg::ST_READY;
                        nxt_in   = S_INT_PUSH;
                     end
                  end
               end
               pdwq_pkg::MODE_TIMER: begin
                  if (q_stat.ready_nz) begin
                     if (run_ff != '0) begin
                        st_we       = 1'b1;
                        st_waddr    = run_ff;
                        st_wdata    = pdwq_pkg::ST_READY;
                        q_cmd.start = 1'b1;
                        q_value     = run_ff;
                        run_in      = '0;
                        nxt_in      = S_DISPATCH;
                        state_in    = S_QWAIT;
                     end else begin
                        state_in = S_DISPATCH;
                     end
                  end
               end
               pdwq_pkg::MODE_REPORT: begin
                  idx_in   = '0;
                  state_in = S_REP_RD;
               end
               default: begin
                  status_in = pdwq_pkg::STATUS_BAD;
               end
            endcase
         end
         S_QWAIT: begin
            if (q_stat.done) begin
               state_in = nxt_ff;
            end
         end
         S_REQ_RM: begin
            q_cmd.start = 1'b1;
            q_cmd.op    = pdwq_pkg::QOP_REMOVE;
            nxt_in      = S_RESULT;
            state_in    = S_QWAIT;
         end
         S_INT_PUSH: begin
            q_cmd.start = 1'b1;
            nxt_in      = S_RESULT;
            state_in    = S_QWAIT;
         end
         S_DISPATCH: begin
            if (run_ff == '0 && q_stat.ready_nz) begin
               q_cmd.start = 1'b1;
               q_cmd.op    = pdwq_pkg::QOP_POP;
               nxt_in      = S_DISP_SET;
               state_in    = S_QWAIT;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_DISP_SET: begin
            st_we    = 1'b1;
            st_waddr = pop_value;
            st_wdata = pdwq_pkg::ST_RUN;
            run_in   = pop_value;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            rsp_tvalid_in = 1'b1;
            rsp_tdata_in  = {1'b0, status_ff, 3'd0, 32'd0, 32'd0, 32'd0, 5'd0, 5'(run_ff)};
            rsp_tuser_in  = 1'b0;
            rsp_tlast_in  = 1'b1;
            state_in      = S_OUT;
         end
         S_REP_RD: begin
            kind_in  = slot_kind;
            state_in = S_REP_CHK;
         end
         S_REP_CHK: begin
            if (idx_ff == '0 || kind_ff != pdwq_pkg::ST_UNUSED) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {1'b0, pdwq_pkg::STATUS_OK, kind_ff, 32'(block_tot),
                                32'(ready_tot), 32'(run_tot), 5'(idx_ff), 5'(run_ff)};
               rsp_tuser_in  = 1'b1;
               rsp_tlast_in  = (idx_ff == hi_ff);
               state_in      = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_REP_RD;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               rsp_tvalid_in = 1'b0;
               if (rsp_tuser_ff && !rsp_tlast_ff) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_REP_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         nxt_ff        <= S_IDLE;
         run_ff        <= '0;
         prev_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < LIM; i++) begin
            st_ff[i] <= pdwq_pkg::ST_UNUSED;
            wt_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         nxt_ff        <= nxt_in;
         run_ff        <= run_in;
         prev_ff       <= prev_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (st_we) begin
            st_ff[st_waddr] <= st_wdata;
            wt_ff[st_waddr] <= wt_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_in_hold: begin
         mode_ff   <= mode_in;
         res_ff    <= res_in;
         pid_ff    <= pid_in;
         delta_ff  <= delta_in;
         idx_ff    <= idx_in;
         hi_ff     <= hi_in;
         kind_ff   <= kind_in;
         status_ff <= status_in;
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
         rsp_tlast_ff <= rsp_tlast_in;
      end
   end

   `PDWQ_ASSERT_IMPL(a_out_blocks_in, rsp_tvalid, !req_tready, "request taken while result pending")
   `PDWQ_ASSERT_IMPL(a_event_single, rsp_tvalid && !rsp_tuser, rsp_tlast, "event result not last")
   `PDWQ_ASSERT_IMPL(a_run_consistent, run_ff != '0, st_ff[run_ff] == pdwq_pkg::ST_RUN, "running slot not in run state")
   `PDWQ_ASSERT_NEXT(a_accept_busy, req_tvalid && req_tready, !req_tready, "ready held after request")

endmodule
